### hdl/mdpa_pkg.sv
// Shared types and constants of the multichannel delay and phase aligner.
package mdpa_pkg;

   localparam int NUM_LANES = 4;
   localparam int COEF_BITS = 16;
   localparam int FRAC_BITS = 14;
   localparam int OFFSET_BITS = 16;

   typedef enum logic [2:0] {
      REG_ALIGN_ENABLE,
      REG_REF_STREAM,
      REG_STREAM_OFFSETS,
      REG_ROT_REAL,
      REG_ROT_IMAG
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_PASS,
      MODE_FILL,
      MODE_ROTATE
   } mode_type;

   typedef struct packed {
      logic                                  wr;
      logic                                  align_enable;
      logic [NUM_LANES-1:0][COEF_BITS-1:0]   rot_re;
      logic [NUM_LANES-1:0][COEF_BITS-1:0]   rot_im;
   } cfg_type;

endpackage

### hdl/multichannel_delay_phase_aligner.sv
// Top level: four-stream variable delay with per-stream phase rotation.
//
//  Channel   Direction  Handshake                    Payload
//  req       in         req_valid / req_ready        req_in{0..3}_re, req_in{0..3}_im
//  rsp       out        rsp_valid / rsp_ready        rsp_out{0..3}_re/_im, rsp_filling
//  csr       in         csr_psel / csr_penable       csr_paddr, csr_pwdata, csr_prdata
//
// One item per cycle when req_ready is high; read, product and result are registered.
// The history memories are read and written once per item, in the acceptance cycle.
// Reset clears the write pointer, fill count and valid flags and resets the registers.
// A stall on rsp holds only full stages; req_ready drops only when all stages are full.
module multichannel_delay_phase_aligner #(
   parameter int STREAM_COUNT = 4,
   parameter int MAX_DELAY    = 1024,
   parameter int SAMPLE_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_in0_re,
   input  logic signed [SAMPLE_BITS-1:0] req_in0_im,
   input  logic signed [SAMPLE_BITS-1:0] req_in1_re,
   input  logic signed [SAMPLE_BITS-1:0] req_in1_im,
   input  logic signed [SAMPLE_BITS-1:0] req_in2_re,
   input  logic signed [SAMPLE_BITS-1:0] req_in2_im,
   input  logic signed [SAMPLE_BITS-1:0] req_in3_re,
   input  logic signed [SAMPLE_BITS-1:0] req_in3_im,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_out0_re,
   output logic signed [SAMPLE_BITS-1:0] rsp_out0_im,
   output logic signed [SAMPLE_BITS-1:0] rsp_out1_re,
   output logic signed [SAMPLE_BITS-1:0] rsp_out1_im,
   output logic signed [SAMPLE_BITS-1:0] rsp_out2_re,
   output logic signed [SAMPLE_BITS-1:0] rsp_out2_im,
   output logic signed [SAMPLE_BITS-1:0] rsp_out3_re,
   output logic signed [SAMPLE_BITS-1:0] rsp_out3_im,
   output logic                          rsp_filling,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [5:0]                    csr_paddr,
   input  logic [63:0]                   csr_pwdata,
   output logic [63:0]                   csr_prdata,
   output logic                          csr_pready
);
   import mdpa_pkg::*;

   localparam int AW = $clog2(MAX_DELAY);
   localparam int DW = $clog2(MAX_DELAY + 1);
   localparam int SW = SAMPLE_BITS;

   cfg_type                       cfg;
   logic [NUM_LANES-1:0][DW-1:0]  dly;
   logic [AW-1:0]                 wp_ff, wp_in;
   logic [DW-1:0]                 fill_ff, fill_in;
   logic                          v1_ff, v1_in;
   logic                          v2_ff, v2_in;
   logic                          v3_ff, v3_in;
   mode_type                      mode1_ff, mode_in;
   logic                          filling2_ff, filling3_ff;
   logic [DW-1:0]                 max_dly;
   logic                          accept, adv1, adv2, adv3;
   logic [NUM_LANES-1:0][SW-1:0]  in_re, in_im, out_re, out_im;

   mdpa_csr #(
      .MAX_DELAY(MAX_DELAY)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg),
      .dly     (dly)
   );

   assign in_re = {req_in3_re, req_in2_re, req_in1_re, req_in0_re};
   assign in_im = {req_in3_im, req_in2_im, req_in1_im, req_in0_im};

   assign adv3      = !v3_ff || rsp_ready;
   assign adv2      = !v2_ff || adv3;
   assign adv1      = !v1_ff || adv2;
   assign req_ready = adv1;
   assign accept    = req_valid && adv1;

   always_comb begin
      max_dly = '0;
      for (int s = 0; s < STREAM_COUNT; s++) begin
         if (dly[s] > max_dly) begin
            max_dly = dly[s];
         end
      end
   end

   always_comb begin
      if (!cfg.align_enable || max_dly == '0) begin
         mode_in = MODE_PASS;
      end else if (fill_ff < max_dly) begin
         mode_in = MODE_FILL;
      end else begin
         mode_in = MODE_ROTATE;
      end
   end

   always_comb begin
      wp_in   = wp_ff;
      fill_in = fill_ff;
      if (accept) begin
         wp_in = (wp_ff == AW'(MAX_DELAY - 1)) ? '0 : wp_ff + 1'b1;
         if (fill_ff < DW'(MAX_DELAY)) begin
            fill_in = fill_ff + 1'b1;
         end
      end
      if (cfg.wr) begin
         fill_in = '0;
      end
      v1_in = adv1 ? req_valid : v1_ff;
      v2_in = adv2 ? v1_ff : v2_ff;
      v3_in = adv3 ? v2_ff : v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         fill_ff <= '0;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
      end else begin
         wp_ff   <= wp_in;
         fill_ff <= fill_in;
         v1_ff   <= v1_in;
         v2_ff   <= v2_in;
         v3_ff   <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         mode1_ff <= mode_in;
      end
      if (adv2) begin
         filling2_ff <= (mode1_ff == MODE_FILL);
      end
      if (adv3) begin
         filling3_ff <= filling2_ff;
      end
   end

   for (genvar s = 0; s < NUM_LANES; s++) begin : g_stream
      if (s < STREAM_COUNT) begin : g_active
         logic [DW:0]          back;
         logic [DW:0]          wrapped;
         logic [AW-1:0]        rd_addr;
         logic [2*SW-1:0]      rd_data;
         logic [SW-1:0]        cur_re1_ff, cur_im1_ff;
         logic                 zero1_ff;
         logic [SW-1:0]        sel_re, sel_im;

         assign back    = (DW+1)'(wp_ff) - (DW+1)'(dly[s]);
         assign wrapped = back[DW] ? back + (DW+1)'(MAX_DELAY) : back;
         assign rd_addr = wrapped[AW-1:0];

         mdpa_hist #(
            .DEPTH(MAX_DELAY),
            .WIDTH(2 * SW)
         ) u_hist (
            .clock   (clock),
            .wr_en   (accept),
            .wr_addr (wp_ff),
            .wr_data ({in_im[s], in_re[s]}),
            .rd_en   (adv1),
            .rd_addr (rd_addr),
            .rd_data (rd_data)
         );

         always_ff @(posedge clock) begin
            if (adv1) begin
               cur_re1_ff <= in_re[s];
               cur_im1_ff <= in_im[s];
               zero1_ff   <= (dly[s] == '0);
            end
         end

         assign sel_re = (mode1_ff == MODE_PASS || zero1_ff) ? cur_re1_ff : rd_data[SW-1:0];
         assign sel_im = (mode1_ff == MODE_PASS || zero1_ff) ? cur_im1_ff : rd_data[2*SW-1:SW];

         mdpa_rot #(
            .SW(SW)
         ) u_rot (
            .clock     (clock),
            .load2     (adv2),
            .load3     (adv3),
            .mode      (mode1_ff),
            .sample_re (sel_re),
            .sample_im (sel_im),
            .coef_re   (cfg.rot_re[s]),
            .coef_im   (cfg.rot_im[s]),
            .out_re    (out_re[s]),
            .out_im    (out_im[s])
         );
      end else begin : g_unused
         assign out_re[s] = '0;
         assign out_im[s] = '0;
      end
   end

   assign rsp_valid   = v3_ff;
   assign rsp_filling = filling3_ff;
   assign rsp_out0_re = out_re[0];
   assign rsp_out0_im = out_im[0];
   assign rsp_out1_re = out_re[1];
   assign rsp_out1_im = out_im[1];
   assign rsp_out2_re = out_re[2];
   assign rsp_out2_im = out_im[2];
   assign rsp_out3_re = out_re[3];
   assign rsp_out3_im = out_im[3];

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= DW'(MAX_DELAY))
      else $error("Fill count exceeds the maximum delay.");

   a_wp_bound: assert property (@(posedge clock) disable iff (reset)
      wp_ff <= AW'(MAX_DELAY - 1))
      else $error("Write pointer left the history range.");

   a_cfg_clear: assert property (@(posedge clock) disable iff (reset)
      cfg.wr |=> fill_ff == '0)
      else $error("Fill count not cleared by a register write.");

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      accept && !cfg.wr && fill_ff < DW'(MAX_DELAY) |=> fill_ff == $past(fill_ff) + 1'b1)
      else $error("Fill count did not advance with an accepted item.");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> v1_ff && v2_ff && v3_ff)
      else $error("Input stalled while the pipeline has an empty stage.");

endmodule

### hdl/mdpa_csr.sv
// Configuration registers and per-stream delay computation.
module mdpa_csr #(
   parameter int MAX_DELAY = 1024,
   localparam int DW = $clog2(MAX_DELAY + 1)
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [5:0]                             paddr,
   input  logic [63:0]                            pwdata,
   output logic [63:0]                            prdata,
   output logic                                   pready,
   output mdpa_pkg::cfg_type                      cfg,
   output logic [mdpa_pkg::NUM_LANES-1:0][DW-1:0] dly
);
   import mdpa_pkg::*;

   localparam logic [63:0] ROT_REAL_RESET  = 64'h4000_4000_4000_4000;

   logic                          align_ff, align_in;
   logic [1:0]                    ref_ff, ref_in;
   logic [63:0]                   offsets_ff, offsets_in;
   logic [63:0]                   rot_re_ff, rot_re_in;
   logic [63:0]                   rot_im_ff, rot_im_in;
   logic                          wr_in;
   logic [NUM_LANES-1:0][DW-1:0]  dly_ff, dly_in;
   logic                          wr_strobe;
   logic [2:0]                    index;

   assign wr_strobe = psel && penable && pwrite;
   assign index     = paddr[5:3];
   assign pready    = 1'b1;

   always_comb begin
      align_in   = align_ff;
      ref_in     = ref_ff;
      offsets_in = offsets_ff;
      rot_re_in  = rot_re_ff;
      rot_im_in  = rot_im_ff;
      wr_in      = 1'b0;
      if (wr_strobe) begin
         case (index)
            REG_ALIGN_ENABLE: begin
               align_in = pwdata[0];
               wr_in    = 1'b1;
            end
            REG_REF_STREAM: begin
               ref_in = pwdata[1:0];
               wr_in  = 1'b1;
            end
            REG_STREAM_OFFSETS: begin
               offsets_in = pwdata;
               wr_in      = 1'b1;
            end
            REG_ROT_REAL: begin
               rot_re_in = pwdata;
               wr_in     = 1'b1;
            end
            REG_ROT_IMAG: begin
               rot_im_in = pwdata;
               wr_in     = 1'b1;
            end
            default: begin
               wr_in = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      logic [OFFSET_BITS-1:0] ref_off;
      logic [OFFSET_BITS+1:0] diff;
      ref_off = offsets_in[{ref_in, 4'b0000} +: OFFSET_BITS];
      for (int s = 0; s < NUM_LANES; s++) begin
         diff = {2'b00, ref_off} - {2'b00, offsets_in[OFFSET_BITS*s +: OFFSET_BITS]};
         if (diff[OFFSET_BITS+1]) begin
            dly_in[s] = '0;
         end else if (diff > (OFFSET_BITS+2)'(MAX_DELAY)) begin
            dly_in[s] = DW'(MAX_DELAY);
         end else begin
            dly_in[s] = diff[DW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         align_ff   <= 1'b0;
         ref_ff     <= '0;
         offsets_ff <= '0;
         rot_re_ff  <= ROT_REAL_RESET;
         rot_im_ff  <= '0;
         dly_ff     <= '0;
      end else begin
         align_ff   <= align_in;
         ref_ff     <= ref_in;
         offsets_ff <= offsets_in;
         rot_re_ff  <= rot_re_in;
         rot_im_ff  <= rot_im_in;
         dly_ff     <= dly_in;
      end
   end

   always_comb begin
      case (index)
         REG_ALIGN_ENABLE:   prdata = {63'd0, align_ff};
         REG_REF_STREAM:     prdata = {62'd0, ref_ff};
         REG_STREAM_OFFSETS: prdata = offsets_ff;
         REG_ROT_REAL:       prdata = rot_re_ff;
         REG_ROT_IMAG:       prdata = rot_im_ff;
         default:            prdata = '0;
      endcase
   end

   assign cfg.wr           = wr_in;
   assign cfg.align_enable = align_ff;
   assign cfg.rot_re       = rot_re_ff;
   assign cfg.rot_im       = rot_im_ff;
   assign dly              = dly_ff;

endmodule

### hdl/mdpa_hist.sv
// Sample history memory of one stream with a registered read port.
module mdpa_hist #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] hist_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= hist_ff[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

### hdl/mdpa_rot.sv
// Complex rotation with rounding and saturation for one stream, or pass or zero.
module mdpa_rot #(
   parameter int SW = 16
) (
   input  logic                                   clock,
   input  logic                                   load2,
   input  logic                                   load3,
   input  mdpa_pkg::mode_type                     mode,
   input  logic signed [SW-1:0]                   sample_re,
   input  logic signed [SW-1:0]                   sample_im,
   input  logic signed [mdpa_pkg::COEF_BITS-1:0]  coef_re,
   input  logic signed [mdpa_pkg::COEF_BITS-1:0]  coef_im,
   output logic signed [SW-1:0]                   out_re,
   output logic signed [SW-1:0]                   out_im
);
   import mdpa_pkg::*;

   localparam int PW = SW + COEF_BITS;
   localparam int XW = PW + 2;
   localparam logic signed [XW-1:0] SMAX = XW'((64'sd1 <<< (SW - 1)) - 64'sd1);
   localparam logic signed [XW-1:0] SMIN = ~SMAX;
   localparam logic signed [XW-1:0] HALF = XW'(64'sd1 <<< (FRAC_BITS - 1));

   mode_type               mode2_ff;
   logic signed [SW-1:0]   samp_re2_ff, samp_im2_ff;
   logic signed [PW-1:0]   p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [SW-1:0]   out_re_ff, out_re_in;
   logic signed [SW-1:0]   out_im_ff, out_im_in;
   logic signed [XW-1:0]   sum_re, sum_im;

   function automatic logic signed [SW-1:0] round_sat(input logic signed [XW-1:0] v);
      logic signed [XW-1:0] t;
      logic signed [XW-1:0] r;
      t = v + HALF;
      r = t >>> FRAC_BITS;
      if (r > SMAX) begin
         r = SMAX;
      end else if (r < SMIN) begin
         r = SMIN;
      end
      return r[SW-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (load2) begin
         mode2_ff    <= mode;
         samp_re2_ff <= sample_re;
         samp_im2_ff <= sample_im;
         p_rr_ff     <= PW'(sample_re) * PW'(coef_re);
         p_ii_ff     <= PW'(sample_im) * PW'(coef_im);
         p_ri_ff     <= PW'(sample_re) * PW'(coef_im);
         p_ir_ff     <= PW'(sample_im) * PW'(coef_re);
      end
      if (load3) begin
         out_re_ff <= out_re_in;
         out_im_ff <= out_im_in;
      end
   end

   assign sum_re = XW'(p_rr_ff) - XW'(p_ii_ff);
   assign sum_im = XW'(p_ri_ff) + XW'(p_ir_ff);

   always_comb begin
      case (mode2_ff)
         MODE_PASS: begin
            out_re_in = samp_re2_ff;
            out_im_in = samp_im2_ff;
         end
         MODE_ROTATE: begin
            out_re_in = round_sat(sum_re);
            out_im_in = round_sat(sum_im);
         end
         default: begin
            out_re_in = '0;
            out_im_in = '0;
         end
      endcase
   end

   assign out_re = out_re_ff;
   assign out_im = out_im_ff;

endmodule
